// ----- rtl/mic_pkg.sv -----
// mic_pkg: shared types and constants of the masked interrupt controller
// request and response beat structs, op codes, register windows, sequencer states
// no dependencies
`timescale 1ns / 1ps

package mic_pkg;

    // default sizes
    localparam int NUM_BANKS_DEF      = 3;
    localparam int LINES_PER_BANK_DEF = 32;

    // field widths fixed by the beat formats
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 6;
    localparam int BANK_IN_W = 2;
    localparam int IRQ_W     = 7;
    localparam int IRQ_BIT_W = 5;

    // register map: window bases, map end, bank slots per window
    localparam logic [ADDR_W-1:0] BASE_STATUS   = 6'h00;
    localparam logic [ADDR_W-1:0] BASE_MASKSTAT = 6'h0c;
    localparam logic [ADDR_W-1:0] BASE_SET      = 6'h18;
    localparam logic [ADDR_W-1:0] BASE_CLEAR    = 6'h24;
    localparam logic [ADDR_W-1:0] MAP_END       = 6'h30;
    localparam int                SLOTS_PER_WIN = 3;

    typedef enum logic [1:0] {
        OP_READ     = 2'd0,
        OP_WRITE    = 2'd1,
        OP_LEVELS   = 2'd2,
        OP_DISPATCH = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        WIN_STATUS   = 2'd0,
        WIN_MASKSTAT = 2'd1,
        WIN_SET      = 2'd2,
        WIN_CLEAR    = 2'd3
    } win_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } state_t;

    typedef struct packed {
        op_t                  op;
        logic [ADDR_W-1:0]    address;
        logic [BANK_IN_W-1:0] bank;
        logic [DATA_W-1:0]    write_data;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [IRQ_W-1:0]  irq_number;
        logic              irq_valid;
        logic              last;
    } rsp_t;

endpackage

// ----- rtl/masked_interrupt_controller.sv -----
// masked_interrupt_controller: level interrupt controller, per-bank levels and masks
// register read/write, line update and dispatch under a small sequencer
// depends on mic_pkg
// a register access or line update returns its single beat from the response register
// after request capture; one item at a time, a new request is taken only in idle; a dispatch
// gives one irq beat per unstalled cycle from the find-first-set unit on the pending snapshot
// reset: line levels clear, all masks set (every line masked), no response pending
`timescale 1ns / 1ps

module masked_interrupt_controller
    import mic_pkg::*;
#(
    parameter int NUM_BANKS      = NUM_BANKS_DEF,
    parameter int LINES_PER_BANK = LINES_PER_BANK_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int LINE_W = $clog2(LINES_PER_BANK);

    // sequencer
    state_t state_reg, state_next;

    // captured request
    op_t                       op_reg;
    logic [ADDR_W-1:0]         addr_reg;
    logic [BANK_IN_W-1:0]      bank_reg;
    logic [LINES_PER_BANK-1:0] data_reg;

    // bank state
    logic [LINES_PER_BANK-1:0] levels_reg [NUM_BANKS];
    logic [LINES_PER_BANK-1:0] mask_reg   [NUM_BANKS];

    // pending snapshot for the scan
    logic [LINES_PER_BANK-1:0] pend_reg, pend_next;

    // response register
    logic rsp_valid_reg;
    rsp_t rsp_reg;

    // control strobes
    logic req_fire, rsp_free, exec_fire, scan_fire;

    // decode and datapath signals
    logic [ADDR_W-1:0]         win_base, win_off;
    win_t                      win;
    logic [1:0]                slot;
    logic                      mapped, bank_ok;
    logic [BANK_IN_W-1:0]      idx;
    logic [BANK_W-1:0]         idx_sel;
    logic                      idx_ok;
    logic [LINES_PER_BANK-1:0] lev_rd, mask_rd, pend_snap;
    logic [LINE_W-1:0]         first_idx;

    assign req_fire = req_valid && !req_stall;
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (rsp_free)
                begin
                    if (op_reg == OP_DISPATCH && pend_snap != '0)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (rsp_free && pend_next == '0)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        req_stall = 1'b1;
        exec_fire = 1'b0;
        scan_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE: req_stall = 1'b0;
            ST_EXEC: exec_fire = rsp_free;
            ST_SCAN: scan_fire = rsp_free;
            default: req_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // capture request beat, drop absent lines
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg   <= req.op;
            addr_reg <= req.address;
            bank_reg <= req.bank;
            data_reg <= req.write_data[LINES_PER_BANK-1:0];
        end
    end

    // address decode: window by range compare, bank slot within window
    always_comb
    begin
        if (addr_reg >= BASE_CLEAR)
        begin
            win      = WIN_CLEAR;
            win_base = BASE_CLEAR;
        end
        else if (addr_reg >= BASE_SET)
        begin
            win      = WIN_SET;
            win_base = BASE_SET;
        end
        else if (addr_reg >= BASE_MASKSTAT)
        begin
            win      = WIN_MASKSTAT;
            win_base = BASE_MASKSTAT;
        end
        else
        begin
            win      = WIN_STATUS;
            win_base = BASE_STATUS;
        end
        win_off = addr_reg - win_base;
        slot    = win_off[3:2];
        mapped  = (addr_reg[1:0] == 2'b00) && (addr_reg < MAP_END)
                  && (32'(slot) < SLOTS_PER_WIN) && (32'(slot) < NUM_BANKS);
        bank_ok = 32'(bank_reg) < NUM_BANKS;
    end

    // one bank index per item: register slot or item bank
    always_comb
    begin
        if (op_reg == OP_READ || op_reg == OP_WRITE)
        begin
            idx    = slot;
            idx_ok = mapped;
        end
        else
        begin
            idx    = bank_reg;
            idx_ok = bank_ok;
        end
        idx_sel   = BANK_W'(idx);
        lev_rd    = idx_ok ? levels_reg[idx_sel] : '0;
        mask_rd   = idx_ok ? mask_reg[idx_sel] : '1;
        pend_snap = lev_rd & ~mask_rd;
    end

    // bank state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BANKS; i++)
            begin
                levels_reg[i] <= '0;
                mask_reg[i]   <= '1;
            end
        end
        else if (exec_fire && idx_ok)
        begin
            if (op_reg == OP_LEVELS)
                levels_reg[idx_sel] <= data_reg;
            else if (op_reg == OP_WRITE && win == WIN_SET)
                mask_reg[idx_sel] <= mask_rd | data_reg;
            else if (op_reg == OP_WRITE && win == WIN_CLEAR)
                mask_reg[idx_sel] <= mask_rd & ~data_reg;
        end
    end

    // find-first-set unit over the pending snapshot
    always_comb
    begin
        first_idx = '0;
        for (int i = LINES_PER_BANK - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
                first_idx = LINE_W'(i);
        end
        pend_next = pend_reg & (pend_reg - LINES_PER_BANK'(1));
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
            pend_reg <= pend_snap;
        else if (scan_fire)
            pend_reg <= pend_next;
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (scan_fire || (exec_fire && !(op_reg == OP_DISPATCH && pend_snap != '0)))
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            rsp_reg.read_data  <= '0;
            rsp_reg.irq_number <= '0;
            rsp_reg.irq_valid  <= 1'b0;
            rsp_reg.last       <= 1'b1;
            if (op_reg == OP_READ && mapped && (win == WIN_STATUS || win == WIN_MASKSTAT))
                rsp_reg.read_data <= DATA_W'(win == WIN_STATUS ? lev_rd : mask_rd);
        end
        else if (scan_fire)
        begin
            rsp_reg.read_data  <= '0;
            rsp_reg.irq_number <= {bank_reg, IRQ_BIT_W'(first_idx)};
            rsp_reg.irq_valid  <= 1'b1;
            rsp_reg.last       <= (pend_next == '0);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // checks
    a_scan_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> pend_reg != '0)
        else $error("scan running with empty pending snapshot");

    a_empty_beat_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.irq_valid |-> rsp.last)
        else $error("non-irq beat without last");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> state_reg == ST_EXEC)
        else $error("accepted beat not executed");

    a_scan_beat_valid: assert property (@(posedge clk) disable iff (!rst_n)
        scan_fire |=> rsp_valid && rsp.irq_valid)
        else $error("scan step without irq beat");

endmodule
